### hdl/sao_pkg.sv
// package: constants, types and codes for the swept box overlap test
`timescale 1ns / 1ps
package sao_pkg;

  localparam int SAMPLES = 1000;
  localparam int SCALE   = 256 * SAMPLES;

  // multiplier operand widths
  localparam int MA_W = 25;
  localparam int MB_W = $clog2(SCALE + 1) + 1;
  localparam int MP_W = MA_W + MB_W;

  // scaled coordinate width
  localparam int ACC_W = $clog2(SCALE + 1) + 19;
  localparam int CNT_W = $clog2(SAMPLES + 1);

  localparam int DATA_W = 176;
  localparam int USER_W = 16;
  localparam int OUT_W  = 8;

  // setup product codes
  localparam logic [2:0] OP_ACC_X = 3'd0;
  localparam logic [2:0] OP_ACC_Y = 3'd1;
  localparam logic [2:0] OP_LO_X  = 3'd2;
  localparam logic [2:0] OP_HI_X  = 3'd3;
  localparam logic [2:0] OP_LO_Y  = 3'd4;
  localparam logic [2:0] OP_HI_Y  = 3'd5;
  localparam logic [2:0] OP_END   = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        [7:0]  a_tag;
    logic        [7:0]  b_tag;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic        [14:0] a_w;
    logic        [14:0] a_h;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic        [14:0] b_w;
    logic        [14:0] b_h;
    logic signed [23:0] prev_x;
    logic signed [23:0] prev_y;
  } item_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } result_t;

endpackage

### hdl/swept_aabb_overlap_test_unit.sv
// top level: stream ports, item unpacking and output register
`timescale 1ns / 1ps
// Swept box overlap test. One item on the s_axis channel describes a moving
// box A (current corner, size, tag, previous corner in q16.8) and a fixed
// box B. One item on the m_axis channel returns the hit flag for it.
// Equal tags give no hit at once. Otherwise A's corner is stepped from its
// previous to its current position in SAMPLES (1000) equal steps, and the
// first step where A touches or overlaps B ends the search with a hit.
// Timing: s_axis_tready is high only while the unit is idle. An item with
// equal tags goes straight to the done state. Otherwise setup computes six
// scaled products on the shared multiplier, then the sample loop tests one
// sample per cycle; a hit ends the loop at that sample, and with no hit the
// loop runs through all SAMPLES steps.
// The output register holds one result; the unit accepts the next item
// while it waits, and holds a finished result in its sequencer if the
// output register is still full and m_axis_tready is low.
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register.
module swept_aabb_overlap_test_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, prev_x, prev_y, zero pad
  input  logic [sao_pkg::DATA_W-1:0]  s_axis_tdata,
  // a_tag, b_tag
  input  logic [sao_pkg::USER_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit, zero pad
  output logic [sao_pkg::OUT_W-1:0]   m_axis_tdata
);
  import sao_pkg::*;

  item_t   item;
  result_t res;
  logic    idle;
  logic    start;
  logic    out_ready;
  logic    m_valid;
  logic    m_hit;

  assign item.a_tag  = s_axis_tuser[7:0];
  assign item.b_tag  = s_axis_tuser[15:8];
  assign item.a_x    = s_axis_tdata[15:0];
  assign item.a_y    = s_axis_tdata[31:16];
  assign item.a_w    = s_axis_tdata[46:32];
  assign item.a_h    = s_axis_tdata[61:47];
  assign item.b_x    = s_axis_tdata[77:62];
  assign item.b_y    = s_axis_tdata[93:78];
  assign item.b_w    = s_axis_tdata[108:94];
  assign item.b_h    = s_axis_tdata[123:109];
  assign item.prev_x = s_axis_tdata[147:124];
  assign item.prev_y = s_axis_tdata[171:148];

  assign s_axis_tready = idle && !rst;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_ready     = !m_valid || m_axis_tready;

  sao_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .out_ready (out_ready),
    .idle      (idle),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (res.valid && out_ready) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_ready) begin
      m_hit <= res.hit;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, m_hit};

endmodule

### hdl/sao_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module sao_mul (
  input  logic                            clk,
  input  logic signed [sao_pkg::MA_W-1:0] op_a,
  input  logic signed [sao_pkg::MB_W-1:0] op_b,
  output logic signed [sao_pkg::MP_W-1:0] prod
);
  import sao_pkg::*;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

### hdl/sao_core.sv
// sequencer, accumulators and overlap compare for the swept box test
`timescale 1ns / 1ps
module sao_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sao_pkg::item_t   item,
  input  logic             out_ready,
  output logic             idle,
  output sao_pkg::result_t res
);
  import sao_pkg::*;

  state_t state, state_next;

  item_t                    itm;
  logic        [2:0]        setup_cnt;
  logic        [2:0]        store_sel;
  logic        [CNT_W-1:0]  run_cnt;
  logic signed [ACC_W-1:0]  acc_x, acc_y, step_x, step_y;
  logic signed [ACC_W-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic signed [ACC_W-1:0]  prod_t;
  logic signed [MA_W-1:0]   op_a;
  logic signed [MB_W-1:0]   op_b;
  logic signed [MP_W-1:0]   prod;
  logic signed [MA_W-1:0]   cur_x_s, cur_y_s;
  logic                     hit;
  logic                     ovl;
  logic                     tags_eq;
  logic                     run_last;

  sao_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign tags_eq   = (item.a_tag == item.b_tag);
  assign store_sel = setup_cnt - 3'd1;
  assign prod_t    = prod[ACC_W-1:0];
  assign run_last  = (run_cnt == CNT_W'(SAMPLES));
  assign ovl = (acc_x >= lo_x) && (acc_x <= hi_x) && (acc_y >= lo_y) && (acc_y <= hi_y);

  // current corner in q16.8
  assign cur_x_s = {item.a_x[15], item.a_x, 8'd0};
  assign cur_y_s = {item.a_y[15], item.a_y, 8'd0};

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (setup_cnt)
      OP_ACC_X: begin
        op_a = MA_W'(itm.prev_x);
        op_b = MB_W'(SAMPLES);
      end
      OP_ACC_Y: begin
        op_a = MA_W'(itm.prev_y);
        op_b = MB_W'(SAMPLES);
      end
      OP_LO_X: begin
        op_a = MA_W'(itm.b_x) - $signed({{(MA_W-15){1'b0}}, itm.a_w});
        op_b = MB_W'(SCALE);
      end
      OP_HI_X: begin
        op_a = MA_W'(itm.b_x) + $signed({{(MA_W-15){1'b0}}, itm.b_w});
        op_b = MB_W'(SCALE);
      end
      OP_LO_Y: begin
        op_a = MA_W'(itm.b_y) - $signed({{(MA_W-15){1'b0}}, itm.a_h});
        op_b = MB_W'(SCALE);
      end
      OP_HI_Y: begin
        op_a = MA_W'(itm.b_y) + $signed({{(MA_W-15){1'b0}}, itm.b_h});
        op_b = MB_W'(SCALE);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = tags_eq ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (setup_cnt == OP_END) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((run_cnt != '0 && ovl) || run_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    res.valid = 1'b0;
    res.hit   = hit;
    unique case (state)
      ST_IDLE:  idle      = 1'b1;
      ST_DONE:  res.valid = 1'b1;
      default: begin
        idle      = 1'b0;
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      setup_cnt <= '0;
      run_cnt   <= '0;
      hit       <= 1'b0;
      if (start) begin
        itm    <= item;
        step_x <= ACC_W'(cur_x_s - MA_W'(item.prev_x));
        step_y <= ACC_W'(cur_y_s - MA_W'(item.prev_y));
      end
    end
    if (state == ST_SETUP) begin
      setup_cnt <= setup_cnt + 3'd1;
      if (setup_cnt != OP_ACC_X) begin
        case (store_sel)
          OP_ACC_X: acc_x <= prod_t;
          OP_ACC_Y: acc_y <= prod_t;
          OP_LO_X:  lo_x  <= prod_t;
          OP_HI_X:  hi_x  <= prod_t;
          OP_LO_Y:  lo_y  <= prod_t;
          OP_HI_Y:  hi_y  <= prod_t;
          default:  lo_x  <= lo_x;
        endcase
      end
    end
    if (state == ST_RUN) begin
      if (run_cnt != '0 && ovl) begin
        hit <= 1'b1;
      end else if (!run_last) begin
        run_cnt <= run_cnt + CNT_W'(1);
        acc_x   <= acc_x + step_x;
        acc_y   <= acc_y + step_y;
      end
    end
  end

endmodule
